@@ sv/psch_pkg.sv @@
// Shared types and constants for the priority/delay task scheduler.
package psch_pkg;

   localparam int QueueDepth = 16;
   localparam int CntW       = 5;

   typedef logic [CntW-1:0] cnt_type;

   typedef enum logic [1:0] {
      REQ_ENQ      = 2'd0,
      REQ_DISPATCH = 2'd1,
      REQ_TICK     = 2'd2,
      REQ_NOP      = 2'd3
   } req_code_type;

   typedef enum logic {
      ST_IDLE,
      ST_MOVE
   } st_type;

   typedef struct packed {
      req_code_type kind;
      logic [7:0]   id;
      logic [7:0]   prio;
      logic [15:0]  delay;
   } cmd_type;

endpackage

@@ sv/psch_front.sv @@
// Request front end: takes items and buffers them in a two-entry queue.
module psch_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_type,
   input  logic [7:0]        req_task_id,
   input  logic [7:0]        req_task_priority,
   input  logic [15:0]       req_start_delay,
   output psch_pkg::cmd_type cmd,
   output logic              cmd_valid,
   input  logic              cmd_pop
);
   import psch_pkg::*;

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cmd_type    new_cmd;

   assign req_ready = (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = mem_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.kind  = req_code_type'(req_type);
      new_cmd.id    = req_task_id;
      new_cmd.prio  = req_task_priority;
      new_cmd.delay = req_start_delay;
      wr_ptr_in     = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in     = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in        = cnt_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

@@ sv/psch_back.sv @@
// Scheduler back end: sorted ready and delayed queues and the result register.
module psch_back (
   input  logic              clock,
   input  logic              reset,
   input  psch_pkg::cmd_type cmd,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_dispatched,
   output logic [7:0]        rsp_run_task_id,
   output logic [4:0]        rsp_ready_count,
   output logic [4:0]        rsp_delayed_count,
   output logic              rsp_all_idle,
   output logic              rsp_overflow
);
   import psch_pkg::*;

   logic [7:0]  rid_ff   [QueueDepth];
   logic [7:0]  rid_in   [QueueDepth];
   logic [7:0]  rpri_ff  [QueueDepth];
   logic [7:0]  rpri_in  [QueueDepth];
   logic [7:0]  wid_ff   [QueueDepth];
   logic [7:0]  wid_in   [QueueDepth];
   logic [7:0]  wpri_ff  [QueueDepth];
   logic [7:0]  wpri_in  [QueueDepth];
   logic [15:0] wtick_ff [QueueDepth];
   logic [15:0] wtick_in [QueueDepth];
   cnt_type     rfill_ff, rfill_in;
   cnt_type     wfill_ff, wfill_in;
   st_type      st_ff, st_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        disp_ff, ovf_ff, idle_ff;
   logic [7:0]  run_id_ff;
   cnt_type     rcnt_ff, wcnt_ff;

   logic        do_rins, do_wins, do_wpop, do_rpop, do_tick, load_rsp, ovf;
   logic        can_move;
   logic [7:0]  ins_id, ins_prio;
   logic [QueueDepth-1:0] rge, wle;

   assign can_move = (wfill_ff != '0) && (wtick_ff[0] == 16'd0)
                     && (rfill_ff < cnt_type'(QueueDepth));

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (cmd_valid && !rsp_valid_ff && cmd.kind == REQ_DISPATCH) begin
               st_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            if (!can_move) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      cmd_pop  = 1'b0;
      do_rins  = 1'b0;
      do_wins  = 1'b0;
      do_wpop  = 1'b0;
      do_rpop  = 1'b0;
      do_tick  = 1'b0;
      load_rsp = 1'b0;
      ovf      = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (cmd_valid && !rsp_valid_ff) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  REQ_ENQ: begin
                     load_rsp = 1'b1;
                     if (cmd.delay == 16'd0) begin
                        if (rfill_ff >= cnt_type'(QueueDepth)) ovf = 1'b1;
                        else do_rins = 1'b1;
                     end else begin
                        if (wfill_ff >= cnt_type'(QueueDepth)) ovf = 1'b1;
                        else do_wins = 1'b1;
                     end
                  end
                  REQ_TICK: begin
                     do_tick  = 1'b1;
                     load_rsp = 1'b1;
                  end
                  REQ_DISPATCH: ;
                  default: load_rsp = 1'b1;
               endcase
            end
         end
         ST_MOVE: begin
            if (can_move) begin
               do_rins = 1'b1;
               do_wpop = 1'b1;
            end else begin
               do_rpop  = (rfill_ff != '0);
               load_rsp = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign ins_id   = (st_ff == ST_MOVE) ? wid_ff[0]  : cmd.id;
   assign ins_prio = (st_ff == ST_MOVE) ? wpri_ff[0] : cmd.prio;

   // queue datapath: parallel compares pick the insert slot
   always_comb begin
      for (int k = 0; k < QueueDepth; k++) begin
         rge[k] = (cnt_type'(k) < rfill_ff) && (rpri_ff[k] >= ins_prio);
         wle[k] = (cnt_type'(k) < wfill_ff) && (wtick_ff[k] <= cmd.delay);
      end
      for (int k = 0; k < QueueDepth; k++) begin
         rid_in[k]   = rid_ff[k];
         rpri_in[k]  = rpri_ff[k];
         wid_in[k]   = wid_ff[k];
         wpri_in[k]  = wpri_ff[k];
         wtick_in[k] = wtick_ff[k];
         if (do_rpop && k < QueueDepth - 1) begin
            rid_in[k]  = rid_ff[k+1];
            rpri_in[k] = rpri_ff[k+1];
         end
         if (do_rins && !rge[k]) begin
            if (k == 0 || rge[(k == 0) ? 0 : k-1]) begin
               rid_in[k]  = ins_id;
               rpri_in[k] = ins_prio;
            end else begin
               rid_in[k]  = rid_ff[(k == 0) ? 0 : k-1];
               rpri_in[k] = rpri_ff[(k == 0) ? 0 : k-1];
            end
         end
         if (do_wpop && k < QueueDepth - 1) begin
            wid_in[k]   = wid_ff[k+1];
            wpri_in[k]  = wpri_ff[k+1];
            wtick_in[k] = wtick_ff[k+1];
         end
         if (do_wins && !wle[k]) begin
            if (k == 0 || wle[(k == 0) ? 0 : k-1]) begin
               wid_in[k]   = cmd.id;
               wpri_in[k]  = cmd.prio;
               wtick_in[k] = cmd.delay;
            end else begin
               wid_in[k]   = wid_ff[(k == 0) ? 0 : k-1];
               wpri_in[k]  = wpri_ff[(k == 0) ? 0 : k-1];
               wtick_in[k] = wtick_ff[(k == 0) ? 0 : k-1];
            end
         end
         if (do_tick && wtick_ff[k] != 16'd0) begin
            wtick_in[k] = wtick_ff[k] - 16'd1;
         end
      end
      rfill_in = rfill_ff + cnt_type'(do_rins) - cnt_type'(do_rpop);
      wfill_in = wfill_ff + cnt_type'(do_wins) - cnt_type'(do_wpop);
      rsp_valid_in = load_rsp ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QueueDepth; k++) begin
         rid_ff[k]   <= rid_in[k];
         rpri_ff[k]  <= rpri_in[k];
         wid_ff[k]   <= wid_in[k];
         wpri_ff[k]  <= wpri_in[k];
         wtick_ff[k] <= wtick_in[k];
      end
      if (load_rsp) begin
         disp_ff   <= do_rpop;
         run_id_ff <= do_rpop ? rid_ff[0] : 8'd0;
         rcnt_ff   <= rfill_in;
         wcnt_ff   <= wfill_in;
         idle_ff   <= (rfill_in == '0) && (wfill_in == '0);
         ovf_ff    <= ovf;
      end
      if (reset) begin
         st_ff        <= ST_IDLE;
         rfill_ff     <= '0;
         wfill_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rfill_ff     <= rfill_in;
         wfill_ff     <= wfill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dispatched    = disp_ff;
   assign rsp_run_task_id   = run_id_ff;
   assign rsp_ready_count   = rcnt_ff;
   assign rsp_delayed_count = wcnt_ff;
   assign rsp_all_idle      = idle_ff;
   assign rsp_overflow      = ovf_ff;

endmodule

@@ sv/priority_delay_task_scheduler_unit.sv @@
// Top level of the priority/delay task scheduler.
// Usage:
//   req_* channel (valid/ready) carries one request item: req_type selects
//   enqueue, dispatch or timer tick; task id, priority and start delay go
//   with an enqueue. Every request gives exactly one item on the rsp_*
//   channel (valid/ready) with the dispatch result, both queue counts, an
//   all-idle flag and an overflow flag for a dropped enqueue.
// Sequence:
//   Enqueue, tick and unused codes are registered in the front queue, then
//   executed by the back end (the execute cycle reads the front queue head),
//   which registers the result on rsp. A dispatch enters the move state and
//   moves the expired delayed entries to the ready queue, one per cycle
//   through the sorted-insert network (at most 16), then loads the result.
//   The front queue holds two items, so requests keep being taken while a
//   result waits; the back end starts the next item the cycle after rsp is
//   taken.
// Reset: synchronous, active high; both queues come up empty.
// Stall: a held rsp item blocks the back end; the front fills and then
//   drops req_ready until the result is taken.
module priority_delay_task_scheduler_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_task_id,
   input  logic [7:0]  req_task_priority,
   input  logic [15:0] req_start_delay,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_dispatched,
   output logic [7:0]  rsp_run_task_id,
   output logic [4:0]  rsp_ready_count,
   output logic [4:0]  rsp_delayed_count,
   output logic        rsp_all_idle,
   output logic        rsp_overflow
);
   import psch_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   // front: accepts and buffers request items
   psch_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_task_id       (req_task_id),
      .req_task_priority (req_task_priority),
      .req_start_delay   (req_start_delay),
      .cmd               (cmd),
      .cmd_valid         (cmd_valid),
      .cmd_pop           (cmd_pop)
   );

   // back: sorted queues, expiry moves and the result register
   psch_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .cmd_valid         (cmd_valid),
      .cmd_pop           (cmd_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_dispatched    (rsp_dispatched),
      .rsp_run_task_id   (rsp_run_task_id),
      .rsp_ready_count   (rsp_ready_count),
      .rsp_delayed_count (rsp_delayed_count),
      .rsp_all_idle      (rsp_all_idle),
      .rsp_overflow      (rsp_overflow)
   );

endmodule

@@ verif/psch_checker.sv @@
// Checker for the scheduler: watches both channels, predicts results and compares them.
module psch_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_task_id,
   input  logic [7:0]  req_task_priority,
   input  logic [15:0] req_start_delay,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_dispatched,
   input  logic [7:0]  rsp_run_task_id,
   input  logic [4:0]  rsp_ready_count,
   input  logic [4:0]  rsp_delayed_count,
   input  logic        rsp_all_idle,
   input  logic        rsp_overflow,
   output int          fail_count,
   output int          pending_count
);
   import psch_pkg::*;

   typedef struct packed {
      logic       dispatched;
      logic [7:0] run_id;
      cnt_type    rdy_cnt;
      cnt_type    dly_cnt;
      logic       idle;
      logic       ovf;
   } sched_result_type;

   logic [7:0]  rdy_id   [QueueDepth];
   logic [7:0]  rdy_prio [QueueDepth];
   int          rdy_n;
   logic [7:0]  dly_id   [QueueDepth];
   logic [7:0]  dly_prio [QueueDepth];
   logic [15:0] dly_ticks[QueueDepth];
   int          dly_n;

   sched_result_type expected_results[$];

   assign pending_count = expected_results.size();

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      fail_count++;
   endtask

   function automatic void put_ready(logic [7:0] id, logic [7:0] prio);
      int pos;
      pos = 0;
      while (pos < rdy_n && rdy_prio[pos] >= prio) pos++;
      for (int k = rdy_n; k > pos; k--) begin
         rdy_id[k]   = rdy_id[k-1];
         rdy_prio[k] = rdy_prio[k-1];
      end
      rdy_id[pos]   = id;
      rdy_prio[pos] = prio;
      rdy_n++;
   endfunction

   function automatic sched_result_type schedule_step(req_code_type kind, logic [7:0] id,
                                                      logic [7:0] prio, logic [15:0] delay);
      sched_result_type r;
      int pos;
      r = '0;
      case (kind)
         REQ_ENQ: begin
            if (delay == 0) begin
               if (rdy_n >= QueueDepth) r.ovf = 1;
               else put_ready(id, prio);
            end else if (dly_n >= QueueDepth) begin
               r.ovf = 1;
            end else begin
               pos = 0;
               while (pos < dly_n && dly_ticks[pos] <= delay) pos++;
               for (int k = dly_n; k > pos; k--) begin
                  dly_id[k]    = dly_id[k-1];
                  dly_prio[k]  = dly_prio[k-1];
                  dly_ticks[k] = dly_ticks[k-1];
               end
               dly_id[pos] = id; dly_prio[pos] = prio; dly_ticks[pos] = delay;
               dly_n++;
            end
         end
         REQ_DISPATCH: begin
            // expired entries move first, as long as the ready queue has room
            while (dly_n > 0 && dly_ticks[0] == 0 && rdy_n < QueueDepth) begin
               put_ready(dly_id[0], dly_prio[0]);
               for (int k = 1; k < dly_n; k++) begin
                  dly_id[k-1] = dly_id[k]; dly_prio[k-1] = dly_prio[k];
                  dly_ticks[k-1] = dly_ticks[k];
               end
               dly_n--;
            end
            if (rdy_n > 0) begin
               r.dispatched = 1;
               r.run_id = rdy_id[0];
               for (int k = 1; k < rdy_n; k++) begin
                  rdy_id[k-1] = rdy_id[k]; rdy_prio[k-1] = rdy_prio[k];
               end
               rdy_n--;
            end
         end
         REQ_TICK: begin
            for (int k = 0; k < dly_n; k++)
               if (dly_ticks[k] != 0) dly_ticks[k]--;
         end
         default: ;
      endcase
      r.rdy_cnt = cnt_type'(rdy_n);
      r.dly_cnt = cnt_type'(dly_n);
      r.idle = (rdy_n == 0 && dly_n == 0);
      return r;
   endfunction

   always @(posedge clock) begin
      sched_result_type want;
      if (reset) begin
         rdy_n = 0;
         dly_n = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("unexpected result item");
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_dispatched !== want.dispatched)
                  report_mismatch("dispatched", rsp_dispatched, want.dispatched);
               if (rsp_run_task_id !== want.run_id)
                  report_mismatch("run_task_id", rsp_run_task_id, want.run_id);
               if (rsp_ready_count !== want.rdy_cnt)
                  report_mismatch("ready_count", rsp_ready_count, want.rdy_cnt);
               if (rsp_delayed_count !== want.dly_cnt)
                  report_mismatch("delayed_count", rsp_delayed_count, want.dly_cnt);
               if (rsp_all_idle !== want.idle)
                  report_mismatch("all_idle", rsp_all_idle, want.idle);
               if (rsp_overflow !== want.ovf)
                  report_mismatch("overflow", rsp_overflow, want.ovf);
            end
         end
         if (req_valid && req_ready)
            expected_results.push_back(schedule_step(req_code_type'(req_type), req_task_id,
                                                     req_task_priority, req_start_delay));
      end
   end

   initial fail_count = 0;

endmodule

@@ verif/tb.sv @@
// Testbench top for the scheduler: stimulus, idling phases and verdict.
module tb;
   import psch_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_type;
   logic [7:0]  req_task_id;
   logic [7:0]  req_task_priority;
   logic [15:0] req_start_delay;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_dispatched;
   logic [7:0]  rsp_run_task_id;
   logic [4:0]  rsp_ready_count;
   logic [4:0]  rsp_delayed_count;
   logic        rsp_all_idle;
   logic        rsp_overflow;
   int          fail_count;
   int          pending_count;

   // idle percentages for each side, changed by phase
   int send_idle_pct;
   int recv_stall_pct;
   // set while the receiver is held off for a long stretch
   logic hold_off;

   priority_delay_task_scheduler_unit dut (.*);

   psch_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Limit: slowest run is ~700 items, each with its dispatch moves, stalls and gaps
   initial begin
      #20_000_000;
      $display("tb failed");
      $finish;
   end

   // Receiver: random stall by percentage, plus the long hold-off.
   initial begin
      rsp_ready = 0;
      forever begin
         @(posedge clock);
         rsp_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Send one item; the valid stays high across back-to-back items.
   task automatic send_item(input req_code_type kind, input logic [7:0] id,
                            input logic [7:0] prio, input logic [15:0] delay);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid         <= 1;
      req_type          <= kind;
      req_task_id       <= id;
      req_task_priority <= prio;
      req_start_delay   <= delay;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Mostly well-formed traffic: enqueues with short delays, ticks and dispatches.
   task automatic send_random_item();
      int pick;
      logic [15:0] delay;
      pick = $urandom_range(99);
      delay = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4));
      if ($urandom_range(2) == 0) delay = 0;
      if (pick < 45)
         send_item(REQ_ENQ, 8'($urandom), 8'($urandom_range(7) * 37), delay);
      else if (pick < 70)
         send_item(REQ_DISPATCH, 8'($urandom), 8'($urandom), 16'($urandom));
      else if (pick < 95)
         send_item(REQ_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
      else
         send_item(REQ_NOP, 8'($urandom), 8'($urandom), 16'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      req_valid         <= 0;
      req_type          <= REQ_NOP;
      req_task_id       <= 0;
      req_task_priority <= 0;
      req_start_delay   <= 0;
      hold_off = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset <= 1;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed: empty dispatch, unused code, field extremes, equal-priority order
      send_item(REQ_DISPATCH, 8'hFF, 8'hFF, 16'hFFFF);
      send_item(REQ_NOP, 8'hFF, 8'hFF, 16'hFFFF);
      send_item(REQ_ENQ, 8'h00, 8'h00, 16'h0000);
      send_item(REQ_ENQ, 8'hFF, 8'hFF, 16'h0000);
      send_item(REQ_ENQ, 8'h11, 8'hFF, 16'h0000);
      send_item(REQ_ENQ, 8'h22, 8'h80, 16'hFFFF);
      send_item(REQ_ENQ, 8'h33, 8'h7F, 16'h0001);
      send_item(REQ_ENQ, 8'h44, 8'h7F, 16'h0001);
      send_item(REQ_TICK, 8'h00, 8'h00, 16'h0000);
      send_item(REQ_TICK, 8'h00, 8'h00, 16'h0000);
      for (int i = 0; i < 5; i++)
         send_item(REQ_DISPATCH, 8'h00, 8'h00, 16'h0000);
      // fill the ready queue past its depth, then the delayed one
      for (int i = 0; i < 17; i++)
         send_item(REQ_ENQ, 8'(i), 8'(i % 3), 16'(i < 17 ? 0 : 1));
      for (int i = 0; i < 17; i++)
         send_item(REQ_ENQ, 8'(100 + i), 8'(255 - i), 16'(1 + i % 2));
      // ready full with expired entries waiting: moving stops
      send_item(REQ_TICK, 8'h00, 8'h00, 16'h0000);
      send_item(REQ_TICK, 8'h00, 8'h00, 16'h0000);
      for (int i = 0; i < 34; i++)
         send_item(REQ_DISPATCH, 8'h00, 8'h00, 16'h0000);
      wait_drained();

      // random phases: none, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 73 : (ph == 3) ? 31 : 0;
         recv_stall_pct = (ph == 2) ? 73 : (ph == 3) ? 31 : 0;
         for (int i = 0; i < 150; i++) begin
            if (ph == 2 && i == 50) begin
               // long hold-off while items keep coming, in its own process
               fork
                  begin
                     hold_off = 1;
                     repeat (200) @(posedge clock);
                     hold_off = 0;
                  end
               join_none
            end
            send_random_item();
         end
         wait_drained();
      end

      if (fail_count == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

@@ sim.f @@
sv/psch_pkg.sv
sv/psch_front.sv
sv/psch_back.sv
sv/priority_delay_task_scheduler_unit.sv
verif/psch_checker.sv
verif/tb.sv
